// ----- design/bsks_pkg.sv -----
// bsks_pkg: sizes, command and status codes and the record type of the
// bounded stack with key search. no dependencies; used by the interfaces
// and by the core.
`timescale 1ns / 1ps

package bsks_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int DATA_W      = 32;
    localparam int CMD_W       = 3;
    localparam int STATUS_W    = 3;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    // command codes
    localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd3;
    localparam logic [CMD_W-1:0] CMD_LIST   = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] ST_DONE     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_MATCH    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;
    localparam logic [STATUS_W-1:0] ST_LISTED   = 3'd5;

    typedef struct packed {
        logic signed [DATA_W-1:0] id;
        logic signed [DATA_W-1:0] price;
        logic signed [DATA_W-1:0] stock;
    } rec_t;

endpackage

// ----- design/bsks_ifs.sv -----
// bsks_req_if and bsks_rsp_if: valid/ready channels of the stack core,
// command beats in and result beats out. depends on bsks_pkg.
`timescale 1ns / 1ps

interface bsks_req_if;
    logic                                   valid;
    logic                                   ready;
    logic        [bsks_pkg::CMD_W-1:0]      cmd;
    logic signed [bsks_pkg::DATA_W-1:0]     item_id;
    logic signed [bsks_pkg::DATA_W-1:0]     price;
    logic signed [bsks_pkg::DATA_W-1:0]     stock;

    modport source (output valid, output cmd, output item_id, output price,
                    output stock, input ready);
    modport sink   (input valid, input cmd, input item_id, input price,
                    input stock, output ready);
endinterface

interface bsks_rsp_if;
    logic                                   valid;
    logic                                   ready;
    logic        [bsks_pkg::STATUS_W-1:0]   status;
    logic signed [bsks_pkg::DATA_W-1:0]     rec_id;
    logic signed [bsks_pkg::DATA_W-1:0]     rec_price;
    logic signed [bsks_pkg::DATA_W-1:0]     rec_stock;
    logic                                   last;

    modport source (output valid, output status, output rec_id, output rec_price,
                    output rec_stock, output last, input ready);
    modport sink   (input valid, input status, input rec_id, input rec_price,
                    input rec_stock, input last, output ready);
endinterface

// ----- design/bounded_stack_with_key_search_core.sv -----
// bounded_stack_with_key_search_core: record stack with push, pop, clear,
// list and search by id. depends on bsks_pkg and the interfaces in bsks_ifs.sv.
//
//   channel  dir  beat
//   req      in   cmd, item_id, price, stock
//   rsp      out  status, rec_id, rec_price, rec_stock, last
//
// push and clear answer directly; pop goes through one registered memory read.
// search and list walk the stack through one read port and one id compare,
// one entry a cycle while the result channel does not stall the walk.
// a new command is taken only in idle with the result register free or draining.
// reset empties the stack; the record memory itself is not cleared.
// a stalled rsp holds the walk in place whenever a beat is due; no beat is dropped.
`timescale 1ns / 1ps

module bounded_stack_with_key_search_core
(
    input  logic          clk,
    input  logic          rst_n,
    bsks_req_if.sink      req,
    bsks_rsp_if.source    rsp
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_POP  = 2'd1;
    localparam logic [1:0] S_WALK = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    localparam int CNT_W  = bsks_pkg::CNT_W;
    localparam int ADDR_W = bsks_pkg::ADDR_W;
    localparam int DATA_W = bsks_pkg::DATA_W;

    bsks_pkg::rec_t mem [bsks_pkg::STACK_DEPTH];

    logic [1:0]          state_reg, state_next;
    logic [CNT_W-1:0]    fill_count_reg, fill_count_next;
    logic [ADDR_W-1:0]   ptr_reg, ptr_next;
    logic                is_list_reg, is_list_next;
    logic [DATA_W-1:0]   key_reg, key_next;
    logic                pend_valid_reg, pend_valid_next;
    bsks_pkg::rec_t      pend_reg, pend_next;
    bsks_pkg::rec_t      rd_data_reg;

    logic                        out_valid_reg, out_valid_next;
    logic [bsks_pkg::STATUS_W-1:0] status_reg, status_next;
    bsks_pkg::rec_t              out_rec_reg, out_rec_next;
    logic                        last_reg, last_next;

    logic                out_free;
    logic                accept;
    logic                load;
    logic                wr_en;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic [CNT_W-1:0]    fill_m1;
    logic [ADDR_W-1:0]   ptr_m1;
    logic                id_match;
    logic                need_emit;
    logic                advance;
    bsks_pkg::rec_t      wr_rec;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE) && out_free;
    assign accept    = req.valid && req.ready;
    assign fill_m1   = fill_count_reg - CNT_W'(1);
    assign ptr_m1    = ptr_reg - ADDR_W'(1);
    assign rd_addr   = (state_reg == S_IDLE) ? fill_m1[ADDR_W-1:0] : ptr_m1;
    assign id_match  = (rd_data_reg.id == key_reg);
    assign need_emit = id_match && pend_valid_reg;

    assign wr_rec.id    = req.item_id;
    assign wr_rec.price = req.price;
    assign wr_rec.stock = req.stock;

    always_comb
    begin
        state_next      = state_reg;
        fill_count_next = fill_count_reg;
        ptr_next        = ptr_reg;
        is_list_next    = is_list_reg;
        key_next        = key_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        wr_en           = 1'b0;
        rd_en           = 1'b0;
        advance         = 1'b0;
        load            = 1'b0;
        status_next     = bsks_pkg::ST_DONE;
        out_rec_next    = '0;
        last_next       = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (req.cmd) inside
                        bsks_pkg::CMD_PUSH:
                        begin
                            load = 1'b1;
                            if (fill_count_reg == CNT_W'(bsks_pkg::STACK_DEPTH))
                            begin
                                status_next = bsks_pkg::ST_FULL;
                            end
                            else
                            begin
                                wr_en           = 1'b1;
                                fill_count_next = fill_count_reg + CNT_W'(1);
                            end
                        end
                        bsks_pkg::CMD_POP:
                        begin
                            if (fill_count_reg == '0)
                            begin
                                load        = 1'b1;
                                status_next = bsks_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                rd_en           = 1'b1;
                                fill_count_next = fill_m1;
                                state_next      = S_POP;
                            end
                        end
                        bsks_pkg::CMD_CLEAR:
                        begin
                            load            = 1'b1;
                            fill_count_next = '0;
                        end
                        bsks_pkg::CMD_SEARCH, bsks_pkg::CMD_LIST:
                        begin
                            if (fill_count_reg == '0)
                            begin
                                load        = 1'b1;
                                status_next = (req.cmd == bsks_pkg::CMD_LIST) ?
                                              bsks_pkg::ST_EMPTY : bsks_pkg::ST_NOTFOUND;
                            end
                            else
                            begin
                                rd_en           = 1'b1;
                                ptr_next        = fill_m1[ADDR_W-1:0];
                                key_next        = req.item_id;
                                is_list_next    = (req.cmd == bsks_pkg::CMD_LIST);
                                pend_valid_next = 1'b0;
                                state_next      = S_WALK;
                            end
                        end
                        default:
                        begin
                            // unused codes are swallowed without a result
                        end
                    endcase
                end
            end
            S_POP:
            begin
                if (out_free)
                begin
                    load            = 1'b1;
                    out_rec_next.id = rd_data_reg.id;
                    state_next      = S_IDLE;
                end
            end
            S_WALK:
            begin
                if (is_list_reg)
                begin
                    if (out_free)
                    begin
                        load         = 1'b1;
                        status_next  = bsks_pkg::ST_LISTED;
                        out_rec_next = rd_data_reg;
                        last_next    = (ptr_reg == '0);
                        advance      = 1'b1;
                    end
                end
                else if (!need_emit || out_free)
                begin
                    // a match is held back until the next one shows it was not the last
                    if (need_emit)
                    begin
                        load         = 1'b1;
                        status_next  = bsks_pkg::ST_MATCH;
                        out_rec_next = pend_reg;
                        last_next    = 1'b0;
                    end
                    if (id_match)
                    begin
                        pend_valid_next = 1'b1;
                        pend_next       = rd_data_reg;
                    end
                    advance = 1'b1;
                end
                if (advance)
                begin
                    if (ptr_reg == '0)
                    begin
                        state_next = is_list_reg ? S_IDLE : S_FIN;
                    end
                    else
                    begin
                        rd_en    = 1'b1;
                        ptr_next = ptr_m1;
                    end
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    load            = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                    if (pend_valid_reg)
                    begin
                        status_next  = bsks_pkg::ST_MATCH;
                        out_rec_next = pend_reg;
                    end
                    else
                    begin
                        status_next = bsks_pkg::ST_NOTFOUND;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = load ? 1'b1 : (out_valid_reg && !rsp.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            fill_count_reg <= '0;
            ptr_reg        <= '0;
            is_list_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_count_reg <= fill_count_next;
            ptr_reg        <= ptr_next;
            is_list_reg    <= is_list_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        pend_reg <= pend_next;
        if (load)
        begin
            status_reg  <= status_next;
            out_rec_reg <= out_rec_next;
            last_reg    <= last_next;
        end
    end

    // record memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[fill_count_reg[ADDR_W-1:0]] <= wr_rec;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = status_reg;
    assign rsp.rec_id    = out_rec_reg.id;
    assign rsp.rec_price = out_rec_reg.price;
    assign rsp.rec_stock = out_rec_reg.stock;
    assign rsp.last      = last_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg <= CNT_W'(bsks_pkg::STACK_DEPTH))
        else $error("stack fill count above depth");

    a_pend_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> ((state_reg == S_WALK && !is_list_reg) || state_reg == S_FIN))
        else $error("held match outside a search");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.cmd == bsks_pkg::CMD_PUSH &&
         fill_count_reg != CNT_W'(bsks_pkg::STACK_DEPTH))
        |=> fill_count_reg == $past(fill_count_reg) + CNT_W'(1))
        else $error("push did not grow the stack");

    a_pop_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.cmd == bsks_pkg::CMD_POP && fill_count_reg != '0)
        |=> state_reg == S_POP && fill_count_reg == $past(fill_m1))
        else $error("pop did not shrink the stack");

    a_result_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (load && state_reg == S_IDLE) |-> accept)
        else $error("result loaded in idle without a command");

endmodule

// ----- dv/bsks_checker.sv -----
// bsks_checker: watches the command and result channels of the stack core,
// keeps its own record stack to predict each result beat and compares them.
// depends on bsks_pkg and the channel interfaces in bsks_ifs.sv.
`timescale 1ns / 1ps

module bsks_checker
    import bsks_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    bsks_req_if     req,
    bsks_rsp_if     rsp,
    output int      fail_count,
    output int      due_count
);

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [DATA_W-1:0] id;
        logic signed [DATA_W-1:0] price;
        logic signed [DATA_W-1:0] stock;
        logic                     last;
    } rsp_beat_t;

    rec_t      stack_mem [STACK_DEPTH];
    int        held;
    rsp_beat_t rsp_due_q [$];
    rsp_beat_t want;
    rec_t      cmd_rec;

    function automatic void owe(logic [STATUS_W-1:0] status, rec_t r, logic last);
        rsp_beat_t b;
        b.status = status;
        b.id     = r.id;
        b.price  = r.price;
        b.stock  = r.stock;
        b.last   = last;
        rsp_due_q.push_back(b);
    endfunction

    // one command against the stack: updates it and queues the beats it owes
    function automatic void apply_stack_cmd(logic [CMD_W-1:0] cmd, rec_t in_rec);
        rec_t popped;
        int   total;
        int   seen;
        popped = '0;
        total  = 0;
        seen   = 0;
        case (cmd)
            CMD_PUSH:
            begin
                if (held == STACK_DEPTH)
                begin
                    owe(ST_FULL, '0, 1'b1);
                end
                else
                begin
                    stack_mem[held] = in_rec;
                    held++;
                    owe(ST_DONE, '0, 1'b1);
                end
            end
            CMD_POP:
            begin
                if (held == 0)
                begin
                    owe(ST_EMPTY, '0, 1'b1);
                end
                else
                begin
                    held--;
                    popped.id = stack_mem[held].id;
                    owe(ST_DONE, popped, 1'b1);
                end
            end
            CMD_CLEAR:
            begin
                held = 0;
                owe(ST_DONE, '0, 1'b1);
            end
            CMD_SEARCH:
            begin
                for (int j = 0; j < held; j++)
                    if (stack_mem[j].id == in_rec.id)
                        total++;
                if (total == 0)
                begin
                    owe(ST_NOTFOUND, '0, 1'b1);
                end
                else
                begin
                    // top of stack first, last flag on the final match
                    for (int j = held - 1; j >= 0; j--)
                    begin
                        if (stack_mem[j].id == in_rec.id)
                        begin
                            seen++;
                            owe(ST_MATCH, stack_mem[j], seen == total);
                        end
                    end
                end
            end
            CMD_LIST:
            begin
                if (held == 0)
                    owe(ST_EMPTY, '0, 1'b1);
                else
                    for (int j = held - 1; j >= 0; j--)
                        owe(ST_LISTED, stack_mem[j], j == 0);
            end
            default:
            begin
                // unused codes are dropped without a result
            end
        endcase
    endfunction

    function automatic void check_field(string name, logic [DATA_W-1:0] exp_val,
                                        logic [DATA_W-1:0] got_val);
        if (got_val !== exp_val)
        begin
            $error("%s: expected %0d, actual %0d", name, $signed(exp_val),
                   $signed(got_val));
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held = 0;
            rsp_due_q.delete();
            due_count = 0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                cmd_rec.id    = req.item_id;
                cmd_rec.price = req.price;
                cmd_rec.stock = req.stock;
                apply_stack_cmd(req.cmd, cmd_rec);
            end
            if (rsp.valid && rsp.ready)
            begin
                if (rsp_due_q.size() == 0)
                begin
                    $error("result beat with none outstanding: status %0d, rec_id %0d",
                           rsp.status, rsp.rec_id);
                    fail_count++;
                end
                else
                begin
                    want = rsp_due_q.pop_front();
                    check_field("status", DATA_W'(want.status), DATA_W'(rsp.status));
                    check_field("rec_id", want.id, rsp.rec_id);
                    check_field("rec_price", want.price, rsp.rec_price);
                    check_field("rec_stock", want.stock, rsp.rec_stock);
                    check_field("last", DATA_W'(want.last), DATA_W'(rsp.last));
                end
            end
            due_count = rsp_due_q.size();
        end
    end

endmodule

// ----- dv/tb_bounded_stack_with_key_search_core.sv -----
// tb_bounded_stack_with_key_search_core: clock, reset and command stimulus for
// the stack core, random result back-pressure and the verdict.
// depends on bsks_pkg, bsks_ifs.sv, the core and dv/bsks_checker.sv.
`timescale 1ns / 1ps

module tb_bounded_stack_with_key_search_core;
    import bsks_pkg::*;

    localparam logic [CMD_W-1:0] CMD_FIRST_UNUSED = 3'd5;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 4 * STACK_DEPTH;
    localparam int PHASES         = 6;
    localparam int PHASE_ITEMS    = 52;
    localparam int LONG_HOLD      = 150;

    logic clk = 1'b0;
    logic rst_n;
    int   fail_count;
    int   due_count;
    int   quiet_cycles;
    int   gap_max;

    logic signed [DATA_W-1:0] corner_vals [4];
    logic signed [DATA_W-1:0] id_pool [8];

    bsks_req_if req_ch();
    bsks_rsp_if rsp_ch();

    bounded_stack_with_key_search_core u_top
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    bsks_checker u_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .fail_count (fail_count),
        .due_count  (due_count)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ends the run when neither channel moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("bounded_stack_with_key_search_core: mismatch");
            $finish;
        end
    end

    task automatic send_cmd(input logic [CMD_W-1:0] c, input logic signed [DATA_W-1:0] id,
                            input logic signed [DATA_W-1:0] pr,
                            input logic signed [DATA_W-1:0] st);
        int gap;
        gap = $urandom_range(0, gap_max);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.cmd     <= c;
        req_ch.item_id <= id;
        req_ch.price   <= pr;
        req_ch.stock   <= st;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    // result side: random stall per beat, one long hold to back up the core
    initial
    begin : rsp_sink
        int beats;
        int stall;
        int stall_max;
        beats = 0;
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            case ((beats / 64) % 3)
                0:       stall_max = 7;
                1:       stall_max = 3;
                default: stall_max = 0;
            endcase
            stall = $urandom_range(0, stall_max);
            if (beats == 100)
                stall = LONG_HOLD;
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clk);
            while (!rsp_ch.valid)
                @(posedge clk);
            beats++;
        end
    end

    initial
    begin : stimulus
        int push_pct;
        int roll;
        logic [CMD_W-1:0] c;
        logic signed [DATA_W-1:0] id;

        rst_n          <= 1'b0;
        req_ch.valid   <= 1'b0;
        req_ch.cmd     <= CMD_PUSH;
        req_ch.item_id <= '0;
        req_ch.price   <= '0;
        req_ch.stock   <= '0;
        gap_max = 7;
        corner_vals[0] = 32'sh8000_0000;
        corner_vals[1] = 32'sh7fff_ffff;
        corner_vals[2] = 32'sh0000_0000;
        corner_vals[3] = -32'sd1;
        for (int k = 0; k < 8; k++)
            id_pool[k] = (k < 4) ? corner_vals[k] : $urandom;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty stack, unused codes, fill with corner values, full,
        // multi-match search, full list, pop, miss, clear
        send_cmd(CMD_POP, '0, '0, '0);
        send_cmd(CMD_LIST, '0, '0, '0);
        send_cmd(CMD_SEARCH, corner_vals[0], '0, '0);
        for (int u = 0; u < 3; u++)
            send_cmd(CMD_FIRST_UNUSED + 3'(u), $urandom, $urandom, $urandom);
        for (int k = 0; k < STACK_DEPTH; k++)
            send_cmd(CMD_PUSH, corner_vals[k % 4], corner_vals[(k + 1) % 4],
                     corner_vals[(k + 2) % 4]);
        send_cmd(CMD_PUSH, 32'sd1, 32'sd1, 32'sd1);
        send_cmd(CMD_SEARCH, corner_vals[3], '0, '0);
        send_cmd(CMD_LIST, '0, '0, '0);
        send_cmd(CMD_POP, '0, '0, '0);
        send_cmd(CMD_SEARCH, 32'sd1, '0, '0);
        send_cmd(CMD_CLEAR, '0, '0, '0);

        // random: phases alternate between filling and draining the stack
        for (int p = 0; p < PHASES; p++)
        begin
            push_pct = (p % 2 == 0) ? 65 : 25;
            gap_max  = (p == 2 || p == 5) ? 0 : 7;
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < push_pct)
                    c = CMD_PUSH;
                else if (roll < push_pct + 20)
                    c = CMD_SEARCH;
                else if (roll < push_pct + 26)
                    c = CMD_LIST;
                else if (roll < push_pct + 28)
                    c = CMD_CLEAR;
                else if (roll < push_pct + 31)
                    c = CMD_FIRST_UNUSED + 3'($urandom_range(0, 2));
                else
                    c = CMD_POP;
                // ids mostly from a small pool so searches hit, often more than once
                id = ($urandom_range(0, 99) < 70) ? id_pool[$urandom_range(0, 7)]
                                                  : $urandom;
                send_cmd(c, id, $urandom, $urandom);
            end
        end

        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (due_count != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && due_count == 0)
            $display("bounded_stack_with_key_search_core: match");
        else
            $display("bounded_stack_with_key_search_core: mismatch");
        $finish;
    end

endmodule

// ----- sim.f -----
design/bsks_pkg.sv
design/bsks_ifs.sv
design/bounded_stack_with_key_search_core.sv
dv/bsks_checker.sv
dv/tb_bounded_stack_with_key_search_core.sv
